// File: sv/hcbd_pkg.sv
// hcbd_pkg: shared types, codes and helpers for the chunked body decoder.
// No dependencies; compile first.
`default_nettype none

package hcbd_pkg;

    // Width of the chunk size and body length counters
    localparam int COUNT_BITS = 32;
    // Width of the body_length result field
    localparam int LEN_BITS   = 32;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Configuration register indexes
    localparam logic CFG_TRAILERS = 1'b0;
    localparam logic CFG_MAX_BODY = 1'b1;

    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

    typedef enum logic [3:0] {
        PH_SIZE    = 4'd0,
        PH_SIZE_LF = 4'd1,
        PH_DATA    = 4'd2,
        PH_DATA_CR = 4'd3,
        PH_DATA_LF = 4'd4,
        PH_TRAILER = 4'd5,
        PH_DONE    = 4'd6,
        PH_ERROR   = 4'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_BIG  = 2'd3
    } kind_t;

    // CR LF CR LF progress in the trailer section
    localparam logic [1:0] TM_NONE   = 2'd0;
    localparam logic [1:0] TM_CR     = 2'd1;
    localparam logic [1:0] TM_CRLF   = 2'd2;
    localparam logic [1:0] TM_CRLFCR = 2'd3;

    typedef struct packed {
        phase_t                  phase;
        logic [COUNT_BITS-1:0]   chunk_rem;
        logic [COUNT_BITS-1:0]   body_count;
        logic                    hex_seen;
        logic [1:0]              term_match;
    } dec_state_t;

    typedef struct packed {
        logic                    valid;
        kind_t                   kind;
        logic [7:0]              out_byte;
        logic [LEN_BITS-1:0]     body_length;
    } dec_result_t;

    typedef struct packed {
        kind_t                   kind;
        logic [7:0]              out_byte;
        logic [LEN_BITS-1:0]     body_length;
    } out_word_t;

    typedef struct packed {
        logic                    valid;
        logic [3:0]              value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            h.value = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            h.value = 4'(b - 8'h37);
        end
        else
        begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// File: sv/hcbd_if.sv
// hcbd_in_if / hcbd_out_if: valid/ready channels of the chunked body decoder.
// Depends on hcbd_pkg.
`default_nettype none

interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hcbd_out_if
    import hcbd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [7:0]          out_byte;
    logic [LEN_BITS-1:0] body_length;

    modport source (output valid, output kind, output out_byte, output body_length,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input body_length,
                    output ready);
endinterface

`default_nettype wire

// File: sv/http_chunked_body_decoder.sv
// http_chunked_body_decoder: HTTP chunked transfer coding decoder, top level.
// Depends on hcbd_pkg, hcbd_if (hcbd_in_if, hcbd_out_if) and hcbd_step.
//
//  channel  | dir | word                                   | handshake
//  ---------+-----+----------------------------------------+-----------------
//  in_ch    | in  | data_byte[7:0]                         | valid/ready
//  out_ch   | out | kind[1:0], out_byte[7:0], body_length  | valid/ready
//  cfg      | in  | cfg_index[0], cfg_wdata[31:0]          | cfg_we, no stall
//
// One input word per cycle while in_ch.ready is high; an accepted byte is
// decoded combinationally into the output register, or the skid if held.
// The output register is backed by a one-word skid register; in_ch.ready drops
// only while the skid holds a word, so a stalled sink costs at most one word.
// Reset (rst_n, async low) returns to the size-line phase with empty counters,
// trailers off and the body limit at 1 MiB. After done or an error every
// byte is taken and dropped until the next reset.
`default_nettype none

module http_chunked_body_decoder
    import hcbd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    hcbd_in_if.sink        in_ch,
    hcbd_out_if.source     out_ch,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [31:0]    cfg_wdata
);

    // configuration
    logic        trailers_reg;
    logic [31:0] max_body_reg;

    // decoder state
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t step_res;

    // output register and skid
    logic        out_valid_reg;
    logic        out_valid_next;
    out_word_t   out_word_reg;
    out_word_t   out_word_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    out_word_t   skid_word_reg;
    out_word_t   skid_word_next;

    logic        in_fire;
    logic        out_fire;
    out_word_t   res_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trailers_reg <= 1'b0;
            max_body_reg <= MAX_BODY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRAILERS: trailers_reg <= cfg_wdata[0];
                CFG_MAX_BODY: max_body_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    hcbd_step u_step (
        .cur               (state_reg),
        .data_byte         (in_ch.data_byte),
        .trailers_expected (trailers_reg),
        .max_body_bytes    (max_body_reg),
        .nxt               (state_next),
        .res               (step_res)
    );

    assign in_ch.ready = !skid_valid_reg;
    assign in_fire     = in_ch.valid && !skid_valid_reg;
    assign out_fire    = out_valid_reg && out_ch.ready;

    assign res_word.kind        = step_res.kind;
    assign res_word.out_byte    = step_res.out_byte;
    assign res_word.body_length = step_res.body_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_SIZE;
            state_reg.chunk_rem  <= '0;
            state_reg.body_count <= '0;
            state_reg.hex_seen   <= 1'b0;
            state_reg.term_match <= TM_NONE;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Output steering: the skid drains first; a fresh result lands in the
    // output register when it is free or being taken, else in the skid.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;

        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else
        begin
            if (out_fire)
            begin
                out_valid_next = 1'b0;
            end
            if (in_fire && step_res.valid)
            begin
                if (out_valid_reg && !out_fire)
                begin
                    skid_valid_next = 1'b1;
                    skid_word_next  = res_word;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res_word;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = out_word_reg.kind;
    assign out_ch.out_byte    = out_word_reg.out_byte;
    assign out_ch.body_length = out_word_reg.body_length;

endmodule

`default_nettype wire

// File: sv/hcbd_step.sv
// hcbd_step: per-byte next-state and result logic of the chunked decoder.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_step
    import hcbd_pkg::*;
(
    input  dec_state_t      cur,
    input  logic [7:0]      data_byte,
    input  logic            trailers_expected,
    input  logic [31:0]     max_body_bytes,
    output dec_state_t      nxt,
    output dec_result_t     res
);

    hex_t                  hex;
    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] rem_dec;
    logic                  too_big;

    assign hex       = hex_decode(data_byte);
    assign count_inc = cur.body_count + COUNT_BITS'(1);
    assign rem_dec   = cur.chunk_rem - COUNT_BITS'(1);
    // limit compared at full width so any counter width works
    assign too_big   = (64'(max_body_bytes) <= 64'(cur.body_count))
                     || (&cur.body_count);

    always_comb
    begin
        nxt             = cur;
        res.valid       = 1'b0;
        res.kind        = KIND_DATA;
        res.out_byte    = 8'd0;
        res.body_length = LEN_BITS'(cur.body_count);

        case (cur.phase)
            PH_SIZE:
            begin
                if (data_byte == CHAR_CR)
                begin
                    if (!cur.hex_seen)
                    begin
                        nxt.phase = PH_ERROR;
                        res.valid = 1'b1;
                        res.kind  = KIND_BAD;
                    end
                    else
                    begin
                        nxt.phase = PH_SIZE_LF;
                    end
                end
                else if (!hex.valid || (cur.chunk_rem[COUNT_BITS-1 -: 4] != 4'd0))
                begin
                    // bad digit, or size would overflow the counter
                    nxt.phase = PH_ERROR;
                    res.valid = 1'b1;
                    res.kind  = KIND_BAD;
                end
                else
                begin
                    nxt.chunk_rem = {cur.chunk_rem[COUNT_BITS-5:0], hex.value};
                    nxt.hex_seen  = 1'b1;
                end
            end
            PH_SIZE_LF:
            begin
                if (data_byte != CHAR_LF)
                begin
                    nxt.phase = PH_ERROR;
                    res.valid = 1'b1;
                    res.kind  = KIND_BAD;
                end
                else
                begin
                    nxt.hex_seen = 1'b0;
                    if (cur.chunk_rem != '0)
                    begin
                        nxt.phase = PH_DATA;
                    end
                    else if (trailers_expected)
                    begin
                        nxt.term_match = TM_NONE;
                        nxt.phase      = PH_TRAILER;
                    end
                    else
                    begin
                        nxt.phase = PH_DONE;
                        res.valid = 1'b1;
                        res.kind  = KIND_DONE;
                    end
                end
            end
            PH_DATA:
            begin
                res.valid = 1'b1;
                if (too_big)
                begin
                    nxt.phase = PH_ERROR;
                    res.kind  = KIND_BIG;
                end
                else
                begin
                    nxt.body_count  = count_inc;
                    nxt.chunk_rem   = rem_dec;
                    res.out_byte    = data_byte;
                    res.body_length = LEN_BITS'(count_inc);
                    if (rem_dec == '0)
                    begin
                        nxt.phase = PH_DATA_CR;
                    end
                end
            end
            PH_DATA_CR:
            begin
                if (data_byte != CHAR_CR)
                begin
                    nxt.phase = PH_ERROR;
                    res.valid = 1'b1;
                    res.kind  = KIND_BAD;
                end
                else
                begin
                    nxt.phase = PH_DATA_LF;
                end
            end
            PH_DATA_LF:
            begin
                if (data_byte != CHAR_LF)
                begin
                    nxt.phase = PH_ERROR;
                    res.valid = 1'b1;
                    res.kind  = KIND_BAD;
                end
                else
                begin
                    nxt.phase     = PH_SIZE;
                    nxt.chunk_rem = '0;
                    nxt.hex_seen  = 1'b0;
                end
            end
            PH_TRAILER:
            begin
                if (data_byte == CHAR_CR)
                begin
                    nxt.term_match = (cur.term_match == TM_CRLF) ? TM_CRLFCR : TM_CR;
                end
                else if (data_byte == CHAR_LF)
                begin
                    if (cur.term_match == TM_CRLFCR)
                    begin
                        nxt.term_match = TM_NONE;
                        nxt.phase      = PH_DONE;
                        res.valid      = 1'b1;
                        res.kind       = KIND_DONE;
                    end
                    else
                    begin
                        nxt.term_match = (cur.term_match == TM_CR) ? TM_CRLF : TM_NONE;
                    end
                end
                else
                begin
                    nxt.term_match = TM_NONE;
                end
            end
            default:
            begin
                // done or error: input is swallowed until reset
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sim/tb_http_chunked_body_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for http_chunked_body_decoder: random chunked bodies
// with random idling on both channels, checked word by word against a predictor.
// Depends on hcbd_pkg, hcbd_if and the decoder RTL.

module tb_http_chunked_body_decoder;
    import hcbd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES = 1175;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    hcbd_in_if  in_if ();
    hcbd_out_if out_if ();

    http_chunked_body_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the decoder registers and config
    // ------------------------------------------------------------------
    phase_t                dec_phase;
    logic [COUNT_BITS-1:0] dec_chunk_left;   // size being parsed, then bytes due
    logic [COUNT_BITS-1:0] dec_body_len;     // body bytes passed so far
    logic                  dec_digit_seen;
    logic [1:0]            dec_crlf_prog;    // CR LF CR LF progress in trailers
    logic                  dec_trailers;
    logic [31:0]           dec_max_body;

    logic [7:0] raw_bytes[$];       // chunked stream still to be sent
    out_word_t  decoded_words[$];   // predicted decoder words, oldest first

    int  bytes_pushed;
    int  bytes_sent;
    int  words_checked;
    int  reg_writes;
    int  mismatches;
    int  cycle_cnt;
    int  send_gap;
    int  recv_gap;
    int  hold_left;
    bit  hold_req;
    bit  quiet;                     // phase with no idling on either side

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Value of a hex digit, -1 for anything else
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 48;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 87;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 55;
        return -1;
    endfunction

    // Advance the predictor by one accepted byte; returns 1 when the byte
    // yields a decoder word, which is then placed in w.
    function automatic bit decode_byte(input logic [7:0] b, output out_word_t w);
        int         nib;
        bit         hit;
        kind_t      k;
        logic [7:0] ob;
        nib = nibble_of(b);
        hit = 1'b0;
        k   = KIND_DATA;
        ob  = 8'h00;
        w   = '{kind: KIND_DATA, out_byte: 8'h00, body_length: '0};
        case (dec_phase)
            PH_SIZE:
            begin
                if (b == CHAR_CR)
                begin
                    // size line must hold at least one digit
                    if (!dec_digit_seen)
                    begin
                        hit = 1'b1;
                        k   = KIND_BAD;
                    end
                    else
                    begin
                        dec_phase = PH_SIZE_LF;
                    end
                end
                else if (nib < 0 || dec_chunk_left[COUNT_BITS-1 -: 4] != 4'd0)
                begin
                    // stray character, or size would overflow the counter
                    hit = 1'b1;
                    k   = KIND_BAD;
                end
                else
                begin
                    dec_chunk_left = {dec_chunk_left[COUNT_BITS-5:0], 4'(nib)};
                    dec_digit_seen = 1'b1;
                end
            end
            PH_SIZE_LF:
            begin
                if (b != CHAR_LF)
                begin
                    hit = 1'b1;
                    k   = KIND_BAD;
                end
                else
                begin
                    dec_digit_seen = 1'b0;
                    if (dec_chunk_left != '0)
                    begin
                        dec_phase = PH_DATA;
                    end
                    else if (dec_trailers)
                    begin
                        // the CR LF of the zero line does not count here
                        dec_crlf_prog = TM_NONE;
                        dec_phase     = PH_TRAILER;
                    end
                    else
                    begin
                        hit = 1'b1;
                        k   = KIND_DONE;
                    end
                end
            end
            PH_DATA:
            begin
                if (64'(dec_body_len) >= 64'(dec_max_body) || (&dec_body_len))
                begin
                    hit = 1'b1;
                    k   = KIND_BIG;
                end
                else
                begin
                    dec_body_len   = dec_body_len + COUNT_BITS'(1);
                    dec_chunk_left = dec_chunk_left - COUNT_BITS'(1);
                    if (dec_chunk_left == '0)
                        dec_phase = PH_DATA_CR;
                    hit = 1'b1;
                    k   = KIND_DATA;
                    ob  = b;
                end
            end
            PH_DATA_CR:
            begin
                if (b != CHAR_CR)
                begin
                    hit = 1'b1;
                    k   = KIND_BAD;
                end
                else
                begin
                    dec_phase = PH_DATA_LF;
                end
            end
            PH_DATA_LF:
            begin
                if (b != CHAR_LF)
                begin
                    hit = 1'b1;
                    k   = KIND_BAD;
                end
                else
                begin
                    dec_phase      = PH_SIZE;
                    dec_chunk_left = '0;
                    dec_digit_seen = 1'b0;
                end
            end
            PH_TRAILER:
            begin
                if (b == CHAR_CR)
                begin
                    dec_crlf_prog = (dec_crlf_prog == TM_CRLF) ? TM_CRLFCR : TM_CR;
                end
                else if (b == CHAR_LF)
                begin
                    if (dec_crlf_prog == TM_CRLFCR)
                    begin
                        dec_crlf_prog = TM_NONE;
                        hit = 1'b1;
                        k   = KIND_DONE;
                    end
                    else
                    begin
                        dec_crlf_prog = (dec_crlf_prog == TM_CR) ? TM_CRLF : TM_NONE;
                    end
                end
                else
                begin
                    dec_crlf_prog = TM_NONE;
                end
            end
            default:
            begin
                // done or error: byte is dropped
            end
        endcase
        if (hit)
        begin
            if (k == KIND_DONE)
                dec_phase = PH_DONE;
            else if (k != KIND_DATA)
                dec_phase = PH_ERROR;
            w.kind        = k;
            w.out_byte    = ob;
            w.body_length = LEN_BITS'(dec_body_len);
        end
        return hit;
    endfunction

    function automatic int idle_gap();
        if (quiet)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 50)
            $display("MISMATCH @%0d: %s", cycle_cnt, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Stream builders
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        raw_bytes.push_back(b);
        bytes_pushed++;
    endtask

    // Hex size line with optional leading zeros and mixed letter case, then CR LF
    task automatic push_size_line(input logic [31:0] size, input int lead);
        int         digits;
        int         i;
        logic [3:0] nib;
        digits = 1;
        for (i = 1; i < 8; i++)
            if ((size >> (4 * i)) != 32'd0)
                digits = i + 1;
        repeat (lead) push_byte(8'h30);
        for (i = digits - 1; i >= 0; i--)
        begin
            nib = size[4*i +: 4];
            if (nib < 4'd10)
                push_byte(8'h30 + nib);
            else
                push_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10);
        end
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
    endtask

    task automatic push_chunk(input int size, input int lead);
        push_size_line(size, lead);
        repeat (size) push_byte(8'($urandom_range(0, 255)));
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
    endtask

    // Sender pause: everything sent, every predicted word seen, and the check
    // made again after a spare wait for bytes that produce no word.
    task automatic wait_drained();
        do
        begin
            while (raw_bytes.size() != 0 || in_if.valid || decoded_words.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
        while (raw_bytes.size() != 0 || in_if.valid || decoded_words.size() != 0);
    endtask

    // Register write; only called while the decoder is idle
    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TRAILERS)
            dec_trailers = val[0];
        else
            dec_max_body = val;
        reg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers the oldest pending byte, predicts on acceptance,
    // then idles for a random number of cycles before the next byte.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : feed_in
        bit        fire;
        out_word_t w;
        if (!rst_n)
        begin
            in_if.valid     <= 1'b0;
            in_if.data_byte <= 8'h00;
            send_gap = 0;
        end
        else
        begin
            fire = in_if.valid && in_if.ready;
            if (fire)
            begin
                if (decode_byte(in_if.data_byte, w))
                    decoded_words.push_back(w);
                void'(raw_bytes.pop_front());
                bytes_sent++;
                send_gap = idle_gap();
            end
            // a word still waiting for ready is left untouched
            if (!in_if.valid || fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end
                else if (raw_bytes.size() != 0)
                begin
                    in_if.valid     <= 1'b1;
                    in_if.data_byte <= raw_bytes[0];
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here once requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
    end

    // ------------------------------------------------------------------
    // Output monitor: checks each accepted word against the oldest
    // prediction, then stalls for a random number of cycles.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch_out
        out_word_t w;
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (decoded_words.size() == 0)
                begin
                    report_mismatch($sformatf("unpredicted word kind %0d byte %02h len %0d",
                        out_if.kind, out_if.out_byte, out_if.body_length));
                end
                else
                begin
                    w = decoded_words.pop_front();
                    if (out_if.kind !== w.kind || out_if.out_byte !== w.out_byte ||
                        out_if.body_length !== w.body_length)
                        report_mismatch($sformatf(
                            "got kind %0d byte %02h len %0d, want kind %0d byte %02h len %0d",
                            out_if.kind, out_if.out_byte, out_if.body_length,
                            w.kind, w.out_byte, w.body_length));
                end
                words_checked++;
                recv_gap = idle_gap();
            end
            if (hold_left != 0)
            begin
                out_if.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_if.ready <= 1'b0;
            end
            else
            begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d words still due",
                cycle_cnt, decoded_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. The decoder ignores everything after done or an error and
    // reset is applied only once, so the whole run is a single chunked body:
    // directed chunks, many random well-formed chunks with register changes
    // between phases, then one randomly chosen ending (clean or broken),
    // then a tail of bytes that must be dropped silently.
    // ------------------------------------------------------------------
    initial
    begin
        int          phase_no;
        int          nchunks;
        int          sel;
        int          size;
        int          k;
        int          nfields;
        logic [7:0]  b;
        logic [31:0] r;
        string       ending_name;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_TRAILERS;
        cfg_wdata       = 32'd0;
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'h00;
        out_if.ready    = 1'b0;
        hold_req        = 1'b0;
        quiet           = 1'b0;
        bytes_pushed    = 0;
        bytes_sent      = 0;
        words_checked   = 0;
        reg_writes      = 0;
        mismatches      = 0;
        cycle_cnt       = 0;

        // predictor reset state
        dec_phase      = PH_SIZE;
        dec_chunk_left = '0;
        dec_body_len   = '0;
        dec_digit_seen = 1'b0;
        dec_crlf_prog  = TM_NONE;
        dec_trailers   = 1'b0;
        dec_max_body   = MAX_BODY_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: limit at its top, trailers off with junk in upper bits
        r    = $urandom;
        r[0] = 1'b0;
        write_reg(CFG_TRAILERS, r);
        write_reg(CFG_MAX_BODY, 32'hFFFF_FFFF);
        push_size_line(32'd1, 0);               // single byte of zero
        push_byte(8'h00);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_size_line(32'd2, 4);               // leading zeros, byte of all ones
        push_byte(8'hFF);
        push_byte(8'h5A);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_size_line(32'd3, 0);               // data that looks like CR, LF, digit
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_byte(8'h30);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        wait_drained();

        // Random well-formed chunks in phases
        phase_no = 0;
        while (bytes_pushed < RANDOM_BYTES)
        begin
            phase_no++;
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
            begin
                r    = $urandom;
                r[0] = 1'($urandom_range(0, 1));
                write_reg(CFG_TRAILERS, r);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                // every value here stays far above any body length we reach
                case ($urandom_range(0, 2))
                    0: write_reg(CFG_MAX_BODY, 32'hFFFF_FFFF);
                    1: write_reg(CFG_MAX_BODY, MAX_BODY_RESET);
                    default: write_reg(CFG_MAX_BODY, $urandom | 32'h0001_0000);
                endcase
            end
            nchunks = $urandom_range(2, 6);
            repeat (nchunks)
            begin
                k = $urandom_range(0, 19);
                if (k < 15)
                    size = $urandom_range(1, 16);
                else if (k < 19)
                    size = $urandom_range(17, 64);
                else
                    size = $urandom_range(65, 255);
                push_chunk(size, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            end
            if (phase_no == 3)
            begin
                // sink holds off while a long chunk keeps arriving
                push_chunk(96, 0);
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            wait_drained();
        end

        // One ending per run, chosen by the seed
        quiet = ($urandom_range(0, 3) == 0);
        sel   = $urandom_range(0, 9);
        case (sel)
            0:
            begin
                ending_name = "zero chunk without trailers";
                write_reg(CFG_TRAILERS, 32'd0);
                push_size_line(32'd0, $urandom_range(0, 2));
            end
            1:
            begin
                ending_name = "zero chunk with trailer fields";
                r    = $urandom;
                r[0] = 1'b1;
                write_reg(CFG_TRAILERS, r);
                push_size_line(32'd0, $urandom_range(0, 2));
                nfields = $urandom_range(0, 3);
                repeat (nfields)
                begin
                    repeat ($urandom_range(1, 12))
                    begin
                        if ($urandom_range(0, 7) == 0)
                            push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                        else
                            push_byte(8'($urandom_range(8'h20, 8'h7E)));
                    end
                    push_byte(CHAR_CR);
                    push_byte(CHAR_LF);
                end
                push_byte(CHAR_CR);
                push_byte(CHAR_LF);
                // with no fields the size line's CR LF does not count
                if (nfields == 0)
                begin
                    push_byte(CHAR_CR);
                    push_byte(CHAR_LF);
                end
            end
            2:
            begin
                ending_name = "stray character in size line";
                if ($urandom_range(0, 1))
                    push_byte(8'h35);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CHAR_CR || nibble_of(b) >= 0);
                push_byte(b);
            end
            3:
            begin
                ending_name = "size line without digits";
                push_byte(CHAR_CR);
                push_byte(CHAR_LF);
            end
            4:
            begin
                ending_name = "CR in size line without LF";
                push_byte(8'h37);
                push_byte(CHAR_CR);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CHAR_LF);
                push_byte(b);
            end
            5:
            begin
                ending_name = "size beyond counter width";
                push_byte(8'h31);
                push_size_line($urandom | 32'h1000_0000, 0);
            end
            6:
            begin
                ending_name = "chunk data not followed by CR";
                size = $urandom_range(1, 8);
                push_size_line(size, 0);
                repeat (size) push_byte(8'($urandom_range(0, 255)));
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CHAR_CR);
                push_byte(b);
            end
            7:
            begin
                ending_name = "chunk CR not followed by LF";
                size = $urandom_range(1, 8);
                push_size_line(size, 0);
                repeat (size) push_byte(8'($urandom_range(0, 255)));
                push_byte(CHAR_CR);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CHAR_LF);
                push_byte(b);
            end
            8:
            begin
                ending_name = "body over the limit";
                k = $urandom_range(0, 5);
                write_reg(CFG_MAX_BODY, 32'(dec_body_len) + 32'(k));
                push_chunk(k + 3, 0);
            end
            default:
            begin
                ending_name = "zero limit with largest chunk size";
                write_reg(CFG_MAX_BODY, 32'd0);
                push_size_line(32'hFFFF_FFFF, 0);
                repeat (3) push_byte(8'($urandom_range(0, 255)));
            end
        endcase

        // decoder has finished; these must all be dropped
        repeat (16) push_byte(8'($urandom_range(0, 255)));

        wait_drained();
        repeat (16) @(posedge clk);

        if (decoded_words.size() != 0)
            report_mismatch($sformatf("%0d predicted words never arrived",
                decoded_words.size()));

        $display("Covered %0d stream bytes, %0d decoder words, %0d register writes",
            bytes_sent, words_checked, reg_writes);
        $display("Body length %0d, ending: %s, %0d mismatches",
            dec_body_len, ending_name, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
